// ===== design/brf_pkg.sv =====
// shared types and constants for the byte ring fifo with crlf line extraction
// no dependencies; used by the controller, datapath and top level

package brf_pkg;

   localparam logic [7:0] BYTE_CR       = 8'h0D;
   localparam logic [7:0] BYTE_LF       = 8'h0A;
   localparam logic [7:0] BYTE_NUL      = 8'h00;
   localparam logic [5:0] MAX_LEN_RESET = 6'd63;

   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_TAKE  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_TERM
   } state_type;

   typedef enum logic {
      RSP_ZERO,
      RSP_MEM
   } rsp_sel_type;

   typedef struct packed {
      logic        do_push;
      logic        do_pop_start;
      logic        do_clear;
      logic        scan_start;
      logic        scan_step;
      logic        emit_rd;
      logic        load_rsp;
      rsp_sel_type rsp_sel;
      logic        rsp_ok;
      logic        rsp_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic full;
      logic empty;
      logic scan_found;
      logic scan_miss;
      logic emit_zero;
   } status_type;

endpackage

// ===== design/byte_ring_fifo_with_crlf_lines.sv =====
// top level of the byte ring fifo with crlf line extraction
// depends on brf_pkg, brf_controller and brf_datapath
// push, clear and empty pop: result registered at the accepting edge
// pop with data: result loaded from the registered store read
// take line: scan held bytes through the lf, or all of them on a miss (empty fifo included),
//   then read and emit each byte, then the terminator; waits while a result is untaken
// synchronous reset empties the fifo and sets max_line_len to 63; store is not cleared

module byte_ring_fifo_with_crlf_lines #(
   parameter int DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_data_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_out,
   output logic       rsp_ok,
   output logic       rsp_last,
   output logic [7:0] rsp_fill_level,
   output logic       rsp_is_empty,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [5:0] csr_max_line_len
);

   brf_pkg::cmd_type    cmd;
   brf_pkg::status_type status;

   assign csr_ready = 1'b1;

   brf_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd)
   );

   brf_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data_in      (req_data_in),
      .csr_valid        (csr_valid),
      .csr_max_line_len (csr_max_line_len),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_out     (rsp_data_out),
      .rsp_ok           (rsp_ok),
      .rsp_last         (rsp_last),
      .rsp_fill_level   (rsp_fill_level),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule

// ===== design/brf_controller.sv =====
// control state machine for the byte ring fifo
// depends on brf_pkg; drives command signals to brf_datapath

module brf_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  brf_pkg::status_type status,
   output brf_pkg::cmd_type    cmd
);

   brf_pkg::state_type state_ff;
   brf_pkg::state_type state_in;
   brf_pkg::kind_type  kind;
   logic               accept;

   assign kind   = brf_pkg::kind_type'(req_kind);
   assign accept = req_valid && (state_ff == brf_pkg::ST_IDLE) && status.out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brf_pkg::ST_IDLE: begin
            if (accept) begin
               case (kind)
                  brf_pkg::KIND_POP: begin
                     if (!status.empty) state_in = brf_pkg::ST_POP;
                  end
                  brf_pkg::KIND_TAKE: state_in = brf_pkg::ST_SCAN;
                  default: state_in = brf_pkg::ST_IDLE;
               endcase
            end
         end
         brf_pkg::ST_POP: begin
            if (status.out_free) state_in = brf_pkg::ST_IDLE;
         end
         brf_pkg::ST_SCAN: begin
            if (status.scan_found) state_in = brf_pkg::ST_EMIT_RD;
            else if (status.scan_miss && status.out_free) state_in = brf_pkg::ST_IDLE;
         end
         brf_pkg::ST_EMIT_RD: begin
            if (status.emit_zero) state_in = brf_pkg::ST_TERM;
            else state_in = brf_pkg::ST_EMIT_WAIT;
         end
         brf_pkg::ST_EMIT_WAIT: begin
            if (status.out_free) state_in = brf_pkg::ST_EMIT_RD;
         end
         brf_pkg::ST_TERM: begin
            if (status.out_free) state_in = brf_pkg::ST_IDLE;
         end
         default: state_in = brf_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == brf_pkg::ST_IDLE) && status.out_free;
      case (state_ff)
         brf_pkg::ST_IDLE: begin
            if (accept) begin
               case (kind)
                  brf_pkg::KIND_PUSH: begin
                     cmd.do_push  = !status.full;
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_sel  = brf_pkg::RSP_ZERO;
                     cmd.rsp_ok   = !status.full;
                     cmd.rsp_last = 1'b1;
                  end
                  brf_pkg::KIND_POP: begin
                     if (status.empty) begin
                        cmd.load_rsp = 1'b1;
                        cmd.rsp_sel  = brf_pkg::RSP_ZERO;
                        cmd.rsp_last = 1'b1;
                     end else begin
                        cmd.do_pop_start = 1'b1;
                     end
                  end
                  brf_pkg::KIND_TAKE: cmd.scan_start = 1'b1;
                  brf_pkg::KIND_CLEAR: begin
                     cmd.do_clear = 1'b1;
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_sel  = brf_pkg::RSP_ZERO;
                     cmd.rsp_ok   = 1'b1;
                     cmd.rsp_last = 1'b1;
                  end
                  default: cmd = '0;
               endcase
            end
         end
         brf_pkg::ST_POP: begin
            cmd.load_rsp = status.out_free;
            cmd.rsp_sel  = brf_pkg::RSP_MEM;
            cmd.rsp_ok   = 1'b1;
            cmd.rsp_last = 1'b1;
         end
         brf_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (!status.scan_found && status.scan_miss) begin
               cmd.load_rsp = status.out_free;
               cmd.rsp_sel  = brf_pkg::RSP_ZERO;
               cmd.rsp_last = 1'b1;
            end
         end
         brf_pkg::ST_EMIT_RD: begin
            cmd.emit_rd = !status.emit_zero;
         end
         brf_pkg::ST_EMIT_WAIT: begin
            cmd.load_rsp = status.out_free;
            cmd.rsp_sel  = brf_pkg::RSP_MEM;
            cmd.rsp_ok   = 1'b1;
         end
         brf_pkg::ST_TERM: begin
            cmd.load_rsp = status.out_free;
            cmd.rsp_sel  = brf_pkg::RSP_ZERO;
            cmd.rsp_ok   = 1'b1;
            cmd.rsp_last = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/brf_datapath.sv =====
// ring store, indices, line scan pipeline and result register
// depends on brf_pkg; commanded by brf_controller

module brf_datapath #(
   parameter int DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  brf_pkg::cmd_type    cmd,
   output brf_pkg::status_type status,
   input  logic [7:0]          req_data_in,
   input  logic                csr_valid,
   input  logic [5:0]          csr_max_line_len,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_data_out,
   output logic                rsp_ok,
   output logic                rsp_last,
   output logic [7:0]          rsp_fill_level,
   output logic                rsp_is_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = (AW > 6) ? AW : 6;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
      ring_next = (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   logic [7:0]    mem [DEPTH];

   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] scan_ptr_ff, scan_ptr_in;
   logic [AW-1:0] scan_left_ff, scan_left_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic          prev_cr_ff, prev_cr_in;
   logic [AW-1:0] emit_ptr_ff, emit_ptr_in;
   logic [5:0]    emit_left_ff, emit_left_in;
   logic [7:0]    rdata_ff;
   logic [5:0]    max_len_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [7:0]    rsp_fill_ff, rsp_fill_in;
   logic          rsp_empty_ff, rsp_empty_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          found;
   logic [AW-1:0] line_len;
   logic [CW-1:0] line_len_x;
   logic [CW-1:0] max_len_x;
   logic [5:0]    emit_cnt;
   logic [31:0]   fill_wide;
   logic          out_free;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign found      = pend_ff && prev_cr_ff && (rdata_ff == brf_pkg::BYTE_LF);
   assign line_len   = pos_ff - 1'b1;
   assign line_len_x = CW'(line_len);
   assign max_len_x  = CW'(max_len_ff);
   assign emit_cnt   = (line_len_x < max_len_x) ? line_len_x[5:0] : max_len_ff;

   assign status.out_free   = out_free;
   assign status.full       = (cnt_ff == AW'(DEPTH - 1));
   assign status.empty      = (cnt_ff == '0);
   assign status.scan_found = found;
   assign status.scan_miss  = !pend_ff && (scan_left_ff == '0);
   assign status.emit_zero  = (emit_left_ff == '0);

   always_comb begin
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      cnt_in       = cnt_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      pos_in       = pos_ff;
      prev_cr_in   = prev_cr_ff;
      emit_ptr_in  = emit_ptr_ff;
      emit_left_in = emit_left_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_ff;

      if (cmd.do_push) begin
         wr_in  = ring_next(wr_ff);
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.do_pop_start) begin
         rd_en   = 1'b1;
         rd_addr = rd_ff;
         rd_in   = ring_next(rd_ff);
         cnt_in  = cnt_ff - 1'b1;
      end
      if (cmd.do_clear) begin
         wr_in  = rd_ff;
         cnt_in = '0;
      end
      if (cmd.scan_start) begin
         scan_ptr_in  = rd_ff;
         scan_left_in = cnt_ff;
         pend_in      = 1'b0;
         pos_in       = '0;
         prev_cr_in   = 1'b0;
         emit_ptr_in  = rd_ff;
      end
      if (cmd.scan_step) begin
         // issue side of the scan
         if (scan_left_ff != '0) begin
            rd_en        = 1'b1;
            rd_addr      = scan_ptr_ff;
            scan_ptr_in  = ring_next(scan_ptr_ff);
            scan_left_in = scan_left_ff - 1'b1;
            pend_in      = 1'b1;
            pend_addr_in = scan_ptr_ff;
         end else begin
            pend_in = 1'b0;
         end
         // compare side of the scan
         if (pend_ff) begin
            prev_cr_in = (rdata_ff == brf_pkg::BYTE_CR);
            pos_in     = pos_ff + 1'b1;
            if (found) begin
               rd_in        = ring_next(pend_addr_ff);
               cnt_in       = cnt_ff - (pos_ff + 1'b1);
               emit_left_in = emit_cnt;
            end
         end
      end
      if (cmd.emit_rd) begin
         rd_en        = 1'b1;
         rd_addr      = emit_ptr_ff;
         emit_ptr_in  = ring_next(emit_ptr_ff);
         emit_left_in = emit_left_ff - 1'b1;
      end

      fill_wide    = 32'(cnt_in);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_empty_in = rsp_empty_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (cmd.rsp_sel == brf_pkg::RSP_MEM) ? rdata_ff : brf_pkg::BYTE_NUL;
         rsp_ok_in    = cmd.rsp_ok;
         rsp_last_in  = cmd.rsp_last;
         rsp_fill_in  = fill_wide[7:0];
         rsp_empty_in = (cnt_in == '0);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ring store
   always_ff @(posedge clock) begin
      if (cmd.do_push) begin
         mem[wr_ff] <= req_data_in;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd_ff        <= '0;
         cnt_ff       <= '0;
         scan_left_ff <= '0;
         pend_ff      <= 1'b0;
         emit_left_ff <= '0;
         max_len_ff   <= brf_pkg::MAX_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         cnt_ff       <= cnt_in;
         scan_left_ff <= scan_left_in;
         pend_ff      <= pend_in;
         emit_left_ff <= emit_left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            max_len_ff <= csr_max_line_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff  <= scan_ptr_in;
      pend_addr_ff <= pend_addr_in;
      pos_ff       <= pos_in;
      prev_cr_ff   <= prev_cr_in;
      emit_ptr_ff  <= emit_ptr_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_is_empty   = rsp_empty_ff;

   // fill count tracks the index distance
   a_fill_matches_indices: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == ((wr_ff >= rd_ff) ? (wr_ff - rd_ff) : (AW'(DEPTH) - rd_ff + wr_ff)))
      else $error("fill count out of step with indices");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.do_push |-> (cnt_ff != AW'(DEPTH - 1)))
      else $error("push carried out on a full ring");

   a_line_within_fill: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && found) |-> (pos_ff < cnt_ff) && (pos_ff != '0))
      else $error("line end beyond held bytes");

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> out_free)
      else $error("result loaded over an untaken transfer");

endmodule
